// ===== hdl/triangle_barycentric_interp_defines.svh =====
// assertion macros shared by the block's modules
`ifndef TRIANGLE_BARYCENTRIC_INTERP_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_INTERP_DEFINES_SVH
`ifndef SYNTHESIS
`define TBI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tbi assertion failed");
`define TBI_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbi assertion failed");
`else
`define TBI_ASSERT(label, prop)
`define TBI_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

// ===== hdl/tbi_pkg.sv =====
`timescale 1ns / 1ps
package tbi_pkg;

  // field widths
  localparam int CW   = 24;
  localparam int HW   = 32;
  // coordinate difference, product and sum widths
  localparam int DW   = CW + 1;
  localparam int UW   = 2 * DW;
  localparam int SW   = UW + 1;
  localparam int NW   = SW + 2;
  // split of a barycentric weight for the height multiply
  localparam int NL   = UW / 2;
  localparam int NH   = UW - NL;
  localparam int PPL  = NL + 1 + HW;
  localparam int PPH  = NH + 1 + HW;
  localparam int TW   = UW + HW + 1;
  localparam int NUMW = TW + 2;
  localparam int MW   = UW + HW;

  // queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTRW  = 3;
  localparam int QCNTW  = 4;
  localparam int QSLACK = 4;

  // accept to result strobe, in clock edges
  localparam int LAT = 3 + 2 + 4 + HW + 1;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_DEGEN   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [HW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [HW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [HW-1:0] cz;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
  } query_t;

  typedef struct packed {
    status_t              status;
    logic signed [HW-1:0] z_value;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    status_t                  status;
    logic [UW-1:0]            det;
    logic [2:0][UW-1:0]       n;
    logic [2:0][HW-1:0]       h;
  } entry_t;

  // divider working item
  typedef struct packed {
    status_t       status;
    logic          neg;
    logic [UW-1:0] det;
    logic [MW-1:0] rem;
    logic [HW-1:0] q;
  } div_t;

endpackage

// ===== hdl/triangle_barycentric_interp.sv =====
// throughput: one item per cycle; the 32-stage restoring divider is the longest part
// busy is high only during reset; the front-to-back queue never fills
// reset: synchronous, active high; clears all valid bits, drops items in flight
`timescale 1ns / 1ps
`include "triangle_barycentric_interp_defines.svh"
module triangle_barycentric_interp (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tbi_pkg::query_t  query,
  output logic             busy,
  output logic             done,
  output tbi_pkg::result_t result
);

  logic            take;
  logic            push;
  tbi_pkg::entry_t fe;
  logic            qvalid;
  tbi_pkg::entry_t qe;
  logic            near_full;
  logic            bvalid;
  tbi_pkg::div_t   bdv;

  assign busy = rst || near_full;
  assign take = start && !busy;

  // classify front
  tbi_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .query (query),
    .push  (push),
    .entry (fe)
  );

  // decoupling queue
  tbi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (fe),
    .dvalid    (qvalid),
    .dout      (qe),
    .near_full (near_full)
  );

  // height weighting
  tbi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .ivalid (qvalid),
    .entry  (qe),
    .ovalid (bvalid),
    .dv     (bdv)
  );

  // division and result register
  tbi_div u_div (
    .clk    (clk),
    .rst    (rst),
    .ivalid (bvalid),
    .dv     (bdv),
    .done   (done),
    .result (result)
  );

  `TBI_ASSERT_IMPLIES(a_latency, take, ##(tbi_pkg::LAT) done)
  `TBI_ASSERT_IMPLIES(a_no_stray, done, $past(take, tbi_pkg::LAT))
  `TBI_ASSERT_IMPLIES(a_zero_off, done && result.status != tbi_pkg::ST_INSIDE, result.z_value == '0)

endmodule

// ===== hdl/tbi_front.sv =====
`timescale 1ns / 1ps
module tbi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  tbi_pkg::query_t query,
  output logic            push,
  output tbi_pkg::entry_t entry
);

  localparam int DW = tbi_pkg::DW;
  localparam int UW = tbi_pkg::UW;
  localparam int SW = tbi_pkg::SW;
  localparam int NW = tbi_pkg::NW;
  localparam int HW = tbi_pkg::HW;

  logic v0, v1, v2;
  logic signed [DW-1:0] dbcy, dacx, dcbx, dacy, dcay, dqcx, dqcy;
  logic signed [UW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [SW-1:0] det, n1, n2;
  logic [2:0][HW-1:0] h0, h1, h2;
  logic signed [NW-1:0] dn, m1, m2, m3;
  logic in_tri;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= take;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // coordinate differences
  always_ff @(posedge clk) begin
    dbcy <= DW'(query.by_coord) - DW'(query.cy);
    dacx <= DW'(query.ax) - DW'(query.cx);
    dcbx <= DW'(query.cx) - DW'(query.bx);
    dacy <= DW'(query.ay) - DW'(query.cy);
    dcay <= DW'(query.cy) - DW'(query.ay);
    dqcx <= DW'(query.qx) - DW'(query.cx);
    dqcy <= DW'(query.qy) - DW'(query.cy);
    h0   <= {query.cz, query.bz, query.az};
  end

  // cross products
  always_ff @(posedge clk) begin
    p1 <= dbcy * dacx;
    p2 <= dcbx * dacy;
    p3 <= dbcy * dqcx;
    p4 <= dcbx * dqcy;
    p5 <= dcay * dqcx;
    p6 <= dacx * dqcy;
    h1 <= h0;
  end

  // determinant and numerators
  always_ff @(posedge clk) begin
    det <= SW'(p1) + SW'(p2);
    n1  <= SW'(p3) + SW'(p4);
    n2  <= SW'(p5) + SW'(p6);
    h2  <= h1;
  end

  // sign normalize and classify
  always_comb begin
    dn = det[SW-1] ? -NW'(det) : NW'(det);
    m1 = det[SW-1] ? -NW'(n1) : NW'(n1);
    m2 = det[SW-1] ? -NW'(n2) : NW'(n2);
    m3 = dn - m1 - m2;
    in_tri = !m1[NW-1] && !m2[NW-1] && !m3[NW-1];
    entry.det = dn[UW-1:0];
    entry.h   = h2;
    entry.n   = '0;
    if (det == '0) begin
      entry.status = tbi_pkg::ST_DEGEN;
    end else if (!in_tri) begin
      entry.status = tbi_pkg::ST_OUTSIDE;
    end else begin
      entry.status = tbi_pkg::ST_INSIDE;
      entry.n      = {m3[UW-1:0], m2[UW-1:0], m1[UW-1:0]};
    end
  end

  assign push = v2;

endmodule

// ===== hdl/tbi_queue.sv =====
`timescale 1ns / 1ps
`include "triangle_barycentric_interp_defines.svh"
module tbi_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tbi_pkg::entry_t din,
  output logic            dvalid,
  output tbi_pkg::entry_t dout,
  output logic            near_full
);

  localparam int QDEPTH = tbi_pkg::QDEPTH;
  localparam int QPTRW  = tbi_pkg::QPTRW;
  localparam int QCNTW  = tbi_pkg::QCNTW;

  tbi_pkg::entry_t mem [QDEPTH];
  logic [QPTRW-1:0] wr_ptr, rd_ptr;
  logic [QCNTW-1:0] count, count_next;
  logic pop;

  // back side never stalls: drain whenever something is held
  assign pop = (count != '0);

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + QCNTW'(1);
      2'b01:   count_next = count - QCNTW'(1);
      default: count_next = count;
    endcase
  end

  // pointers, count and read register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      dvalid <= 1'b0;
    end else begin
      count  <= count_next;
      dvalid <= pop;
      if (push) begin
        wr_ptr <= wr_ptr + QPTRW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTRW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
    dout <= mem[rd_ptr];
  end

  assign near_full = (count >= QCNTW'(QDEPTH - tbi_pkg::QSLACK));

  `TBI_ASSERT_IMPLIES(a_no_overflow, push, count < QCNTW'(QDEPTH))
  `TBI_ASSERT_IMPLIES(a_pop_next, count != '0, ##1 dvalid)
  `TBI_ASSERT_IMPLIES(a_empty_idle, count == '0, ##1 !dvalid)

endmodule

// ===== hdl/tbi_back.sv =====
`timescale 1ns / 1ps
module tbi_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            ivalid,
  input  tbi_pkg::entry_t entry,
  output logic            ovalid,
  output tbi_pkg::div_t   dv
);

  localparam int UW   = tbi_pkg::UW;
  localparam int NL   = tbi_pkg::NL;
  localparam int PPL  = tbi_pkg::PPL;
  localparam int PPH  = tbi_pkg::PPH;
  localparam int TW   = tbi_pkg::TW;
  localparam int NUMW = tbi_pkg::NUMW;
  localparam int MW   = tbi_pkg::MW;

  typedef struct packed {
    tbi_pkg::status_t status;
    logic [UW-1:0]    det;
  } ctl_t;

  logic v1, v2, v3;
  ctl_t c1, c2, c3;
  logic signed [PPL-1:0] pl [3];
  logic signed [PPH-1:0] ph [3];
  logic signed [TW-1:0]  t  [3];
  logic signed [NUMW-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      v1     <= ivalid;
      v2     <= v1;
      v3     <= v2;
      ovalid <= v3;
    end
  end

  // partial products of weight halves by heights
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl[k] <= $signed({1'b0, entry.n[k][NL-1:0]}) * $signed(entry.h[k]);
      ph[k] <= $signed({1'b0, entry.n[k][UW-1:NL]}) * $signed(entry.h[k]);
    end
    c1 <= '{status: entry.status, det: entry.det};
  end

  // recombine halves
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      t[k] <= (TW'(ph[k]) <<< NL) + TW'(pl[k]);
    end
    c2 <= c1;
  end

  // weighted height sum
  always_ff @(posedge clk) begin
    num <= NUMW'(t[0]) + NUMW'(t[1]) + NUMW'(t[2]);
    c3  <= c2;
  end

  // magnitude and sign for the divider
  always_ff @(posedge clk) begin
    dv.status <= c3.status;
    dv.det    <= c3.det;
    dv.neg    <= num[NUMW-1];
    dv.rem    <= num[NUMW-1] ? MW'(-num) : MW'(num);
    dv.q      <= '0;
  end

endmodule

// ===== hdl/tbi_div.sv =====
`timescale 1ns / 1ps
module tbi_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             ivalid,
  input  tbi_pkg::div_t    dv,
  output logic             done,
  output tbi_pkg::result_t result
);

  localparam int HW = tbi_pkg::HW;
  localparam int MW = tbi_pkg::MW;

  tbi_pkg::div_t st [HW+1];
  logic [HW:0] vld;

  assign st[0]  = dv;
  assign vld[0] = ivalid;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < HW; i++) begin : g_stage
    localparam int B = HW - 1 - i;
    logic [MW-1:0] cmp;
    tbi_pkg::div_t nxt;

    always_comb begin
      nxt = st[i];
      cmp = MW'(st[i].det) << B;
      if (st[i].rem >= cmp) begin
        nxt.rem  = st[i].rem - cmp;
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      st[i+1] <= nxt;
    end
  end

  // result register: apply sign, zero for outside or degenerate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[HW];
    end
  end

  always_ff @(posedge clk) begin
    result.status <= st[HW].status;
    if (st[HW].status == tbi_pkg::ST_INSIDE) begin
      result.z_value <= st[HW].neg ? -st[HW].q : st[HW].q;
    end else begin
      result.z_value <= '0;
    end
  end

endmodule
